FILE: src/psa_pkg.sv
// package for the pairwise shortest angle core: constants, pipeline records, arctangent table
// used by every module of the block, no dependencies
`timescale 1ns / 1ps
package psa_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DIM    = 4;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int WORD_W     = 4 * COORD_BITS;
  localparam int VAL_W      = 34;
  localparam int SQRT_CELLS = 31;
  localparam int ROT_CELLS  = 30;
  localparam int STEP_W     = 5;
  // issue/read, multiply, sum, square, then the two cell chains
  localparam int PIPE_STAGES = 4 + SQRT_CELLS + ROT_CELLS;

  typedef enum logic {
    REG_DIMENSION = 1'b0,
    REG_RAW       = 1'b1
  } reg_idx_e;

  // sideband of one result travelling down the pipeline
  typedef struct packed {
    logic                     valid;
    logic                     use_acos;
    logic                     last;
    logic                     ovf;
    logic [IDX_W-1:0]         earlier;
    logic [IDX_W-1:0]         current;
    logic signed [VAL_W-1:0]  value;
  } meta_t;

  // integer square root cell record, x rides along for the rotation setup
  typedef struct packed {
    logic [60:0]        v;
    logic [60:0]        r;
    logic signed [31:0] x;
  } sq_t;

  // vectoring rotation record
  typedef struct packed {
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] z;
  } cd_t;

  // arctangent of 2^-s, 2^30 = pi/2 scale
  function automatic logic [29:0] atan_f(input logic [STEP_W-1:0] s);
    logic [29:0] a;
    unique case (s)
      5'd0:  a = 30'h20000000;
      5'd1:  a = 30'h12E4051E;
      5'd2:  a = 30'h09FB385B;
      5'd3:  a = 30'h051111D4;
      5'd4:  a = 30'h028B0D43;
      5'd5:  a = 30'h0145D7E1;
      5'd6:  a = 30'h00A2F61E;
      5'd7:  a = 30'h00517C55;
      5'd8:  a = 30'h0028BE53;
      5'd9:  a = 30'h00145F2F;
      5'd10: a = 30'h000A2F98;
      5'd11: a = 30'h000517CC;
      5'd12: a = 30'h00028BE6;
      5'd13: a = 30'h000145F3;
      5'd14: a = 30'h0000A2FA;
      5'd15: a = 30'h0000517D;
      5'd16: a = 30'h000028BE;
      5'd17: a = 30'h0000145F;
      5'd18: a = 30'h00000A30;
      5'd19: a = 30'h00000518;
      5'd20: a = 30'h0000028C;
      5'd21: a = 30'h00000146;
      5'd22: a = 30'h000000A3;
      5'd23: a = 30'h00000051;
      5'd24: a = 30'h00000029;
      5'd25: a = 30'h00000014;
      5'd26: a = 30'h0000000A;
      5'd27: a = 30'h00000005;
      5'd28: a = 30'h00000003;
      5'd29: a = 30'h00000001;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

endpackage

FILE: src/psa_store.sv
// point store: one write port, one registered read port
// depends on psa_pkg
`timescale 1ns / 1ps
module psa_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [psa_pkg::IDX_W-1:0]  waddr_i,
  input  logic [psa_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [psa_pkg::IDX_W-1:0]  raddr_i,
  output logic [psa_pkg::WORD_W-1:0] rdata_o
);
  import psa_pkg::*;

  logic [WORD_W-1:0] mem [MAX_POINTS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/psa_sqrt_cell.sv
// one restoring step of the integer square root chain
// depends on psa_pkg
`timescale 1ns / 1ps
module psa_sqrt_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [psa_pkg::STEP_W-1:0]  step_i,
  input  psa_pkg::sq_t                d_i,
  output psa_pkg::sq_t                q_o
);
  import psa_pkg::*;

  logic [60:0] bit_w;
  logic [61:0] sum_w;
  sq_t         cell_d, cell_q;

  always_comb begin
    bit_w  = 61'(1) << {step_i, 1'b0};
    sum_w  = {1'b0, d_i.r} + {1'b0, bit_w};
    cell_d = d_i;
    if ({1'b0, d_i.v} >= sum_w) begin
      cell_d.v = d_i.v - sum_w[60:0];
      cell_d.r = (d_i.r >> 1) + bit_w;
    end else begin
      cell_d.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

FILE: src/psa_cordic_cell.sv
// one vectoring rotation step, stops turning once y reaches zero
// depends on psa_pkg
`timescale 1ns / 1ps
module psa_cordic_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [psa_pkg::STEP_W-1:0]  step_i,
  input  psa_pkg::cd_t                d_i,
  output psa_pkg::cd_t                q_o
);
  import psa_pkg::*;

  logic signed [33:0] xs, ys, at;
  cd_t                cell_d, cell_q;

  always_comb begin
    xs     = d_i.cx >>> step_i;
    ys     = d_i.cy >>> step_i;
    at     = 34'(atan_f(step_i));
    cell_d = d_i;
    if (d_i.cy > 0) begin
      cell_d.cx = d_i.cx + ys;
      cell_d.cy = d_i.cy - xs;
      cell_d.z  = d_i.z + at;
    end else if (d_i.cy < 0) begin
      cell_d.cx = d_i.cx - ys;
      cell_d.cy = d_i.cy + xs;
      cell_d.z  = d_i.z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

FILE: src/pairwise_shortest_angle_core.sv
// top level of the pairwise shortest angle core: sequencer, store, product stages, cell chains
// depends on psa_pkg, psa_store, psa_sqrt_cell, psa_cordic_cell
`timescale 1ns / 1ps
// Points of a sample enter one item at a time and are kept in a 64-entry store. Point j
// yields j results, pairing it with points 0..j-1 in that order; the first point of a
// sample yields none, and a point that finds the store full yields one flagged result.
// An item is accepted, then the sequencer issues one pair per cycle from the store's read port
// whenever the pipeline advances, so an item that pairs with j stored points occupies the input
// until its last pair is issued; the next item is taken right after the last pair is
// issued. Pairs flow through the pipeline stages: store read, four multipliers,
// sum and clamp, square, a chain of 31 square root cells and a chain of 30 rotation cells
// that form the arc cosine. The whole pipeline stalls while a result waits at the output.
// Configuration writes must only happen while no result is outstanding.
module pairwise_shortest_angle_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [2:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                start_sample_i,
  input  logic signed [16:0]  coord_0_i,
  input  logic signed [15:0]  coord_1_i,
  input  logic signed [15:0]  coord_2_i,
  input  logic signed [15:0]  coord_3_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [33:0]  pair_value_o,
  output logic [5:0]          earlier_index_o,
  output logic [5:0]          current_index_o,
  output logic                last_of_run_o,
  output logic                overflow_o
);
  import psa_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  // configuration
  logic [2:0] dim_q;
  logic       raw_q;
  logic [2:0] dim_eff;
  logic       angular;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= 3'd1;
      raw_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DIMENSION: dim_q <= cfg_data_i;
        REG_RAW:       raw_q <= cfg_data_i[0];
      endcase
    end
  end

  always_comb begin
    if (dim_q == 3'd0) dim_eff = 3'd1;
    else if (dim_q > 3'(MAX_DIM)) dim_eff = 3'(MAX_DIM);
    else dim_eff = dim_q;
  end
  assign angular = (dim_eff == 3'd1);

  // pipeline advances when the output register is free
  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || out_ready_i;

  // sequencer
  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  idx_q, jcur_q;
  logic              ovf_q;
  logic [WORD_W-1:0] cur_q;
  logic [CNT_W-1:0]  cnt_eff;
  logic              full;
  logic              accept;
  logic              last_issue;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_eff    = start_sample_i ? '0 : cnt_q;
  assign full       = (cnt_eff >= CNT_W'(MAX_POINTS));
  assign last_issue = ovf_q || (idx_q == jcur_q - IDX_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      jcur_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= cnt_eff;
            idx_q <= '0;
            if (full) begin
              ovf_q   <= 1'b1;
              state_q <= ST_RUN;
            end else begin
              ovf_q  <= 1'b0;
              cnt_q  <= cnt_eff + CNT_W'(1);
              jcur_q <= cnt_eff[IDX_W-1:0];
              // first point of a sample pairs with nothing
              if (cnt_eff != '0) state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (last_issue) state_q <= ST_IDLE;
            else idx_q <= idx_q + IDX_W'(1);
          end
        end
      endcase
    end
  end

  // current point, raw 16-bit words
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= {coord_3_i, coord_2_i, coord_1_i, coord_0_i[15:0]};
    end
  end

  // store
  logic [WORD_W-1:0] rd_data;

  psa_store u_store (
    .clk_i   (clk_i),
    .we_i    (accept && !full),
    .waddr_i (cnt_eff[IDX_W-1:0]),
    .wdata_i ({coord_3_i, coord_2_i, coord_1_i, coord_0_i[15:0]}),
    .re_i    (adv),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // sideband chain, one entry per stage
  meta_t meta_q [PIPE_STAGES];
  meta_t issue_m, sum_m;

  always_comb begin
    issue_m          = '0;
    issue_m.valid    = (state_q == ST_RUN);
    issue_m.ovf      = ovf_q;
    issue_m.last     = last_issue;
    issue_m.earlier  = ovf_q ? '0 : idx_q;
    issue_m.current  = ovf_q ? '0 : jcur_q;
  end

  // stage 1: read data arrives, current point travels with it
  logic [WORD_W-1:0] cur1_q;
  always_ff @(posedge clk_i) begin
    if (adv) cur1_q <= cur_q;
  end

  // stage 2: products and angular difference
  logic signed [31:0]       prod_d [4];
  logic signed [31:0]       prod_q [4];
  logic signed [VAL_W-1:0]  ang_d, ang_q;
  logic signed [16:0]       diff, adiff;
  logic signed [17:0]       tdist, atdist;
  logic signed [17:0]       shortest;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < dim_eff) begin
        prod_d[k] = $signed(rd_data[k*COORD_BITS +: COORD_BITS])
                  * $signed(cur1_q[k*COORD_BITS +: COORD_BITS]);
      end else begin
        prod_d[k] = '0;
      end
    end
    diff     = $signed({1'b0, rd_data[15:0]}) - $signed({1'b0, cur1_q[15:0]});
    adiff    = (diff < 0) ? -diff : diff;
    tdist    = 18'sd32768 - 18'(adiff);
    atdist   = (tdist < 0) ? -tdist : tdist;
    shortest = 18'sd32768 - atdist;
    ang_d    = raw_q ? VAL_W'(diff) : VAL_W'(shortest);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      ang_q  <= ang_d;
    end
  end

  // stage 3: dot product, result selection, clamp to plus or minus one
  localparam logic signed [VAL_W-1:0] ONE_Q30 = VAL_W'(1) <<< 30;
  logic signed [VAL_W-1:0] dot;
  logic signed [VAL_W-1:0] xcl;
  logic signed [31:0]      x_q;

  always_comb begin
    dot = VAL_W'(prod_q[0]) + VAL_W'(prod_q[1]) + VAL_W'(prod_q[2]) + VAL_W'(prod_q[3]);
    if (dot > ONE_Q30) xcl = ONE_Q30;
    else if (dot < -ONE_Q30) xcl = -ONE_Q30;
    else xcl = dot;
    sum_m          = meta_q[1];
    sum_m.use_acos = !meta_q[1].ovf && !angular && !raw_q;
    if (meta_q[1].ovf) sum_m.value = '0;
    else if (angular) sum_m.value = ang_q;
    else sum_m.value = dot;
  end

  always_ff @(posedge clk_i) begin
    if (adv) x_q <= xcl[31:0];
  end

  // stage 4: radicand 1 - x^2
  logic [30:0] ax;
  logic [61:0] xsq;
  sq_t         sq0_d, sq0_q;

  always_comb begin
    ax      = (x_q < 0) ? 31'(-x_q) : 31'(x_q);
    xsq     = 62'(ax) * 62'(ax);
    sq0_d.v = 61'((62'(1) << 60) - xsq);
    sq0_d.r = '0;
    sq0_d.x = x_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) sq0_q <= sq0_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PIPE_STAGES; s++) meta_q[s] <= '0;
    end else if (adv) begin
      meta_q[0] <= issue_m;
      meta_q[1] <= meta_q[0];
      meta_q[2] <= sum_m;
      for (int s = 3; s < PIPE_STAGES; s++) meta_q[s] <= meta_q[s-1];
    end
  end

  // square root chain, largest step first
  sq_t sq_w [SQRT_CELLS+1];
  assign sq_w[0] = sq0_q;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    psa_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (STEP_W'(SQRT_CELLS - 1 - k)),
      .d_i    (sq_w[k]),
      .q_o    (sq_w[k+1])
    );
  end

  // rotation setup: negative cosine starts a quarter turn over
  cd_t cd_w [ROT_CELLS+1];
  sq_t sq_end;
  assign sq_end = sq_w[SQRT_CELLS];

  always_comb begin
    if (sq_end.x < 0) begin
      cd_w[0].cx = 34'(sq_end.r);
      cd_w[0].cy = -34'(sq_end.x);
      cd_w[0].z  = 34'sd1 <<< 30;
    end else begin
      cd_w[0].cx = 34'(sq_end.x);
      cd_w[0].cy = 34'(sq_end.r);
      cd_w[0].z  = '0;
    end
  end

  for (genvar k = 0; k < ROT_CELLS; k++) begin : g_rot
    psa_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (STEP_W'(k)),
      .d_i    (cd_w[k]),
      .q_o    (cd_w[k+1])
    );
  end

  // angle clamp to [0, pi] and rounding to 32768 = pi
  logic signed [33:0] zc, zr;
  meta_t              tail_m;
  assign tail_m = meta_q[PIPE_STAGES-1];

  always_comb begin
    if (cd_w[ROT_CELLS].z < 0) zc = '0;
    else if (cd_w[ROT_CELLS].z > (34'sd1 <<< 31)) zc = 34'sd1 <<< 31;
    else zc = cd_w[ROT_CELLS].z;
    zr = (zc + 34'sd32768) >>> 16;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail_m.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail_m.valid) begin
      pair_value_o    <= tail_m.use_acos ? zr : tail_m.value;
      earlier_index_o <= tail_m.earlier;
      current_index_o <= tail_m.current;
      last_of_run_o   <= tail_m.last;
      overflow_o      <= tail_m.ovf;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store size");

  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !ovf_q) |-> (idx_q < jcur_q))
    else $error("pair issued past current point");

  a_ovf_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (last_of_run_o && pair_value_o == '0
                                     && earlier_index_o == '0))
    else $error("dropped point result malformed");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !overflow_o) |-> (earlier_index_o < current_index_o))
    else $error("earlier index not below current index");

endmodule

FILE: sim/pairwise_shortest_angle_core_test.sv
// self-checking testbench for the pairwise shortest angle core
// depends on psa_pkg and pairwise_shortest_angle_core; stimulus, scoreboard and idling all here
`timescale 1ns / 1ps
module pairwise_shortest_angle_core_test;
  import psa_pkg::*;

  // one point as it enters the block
  typedef struct {
    logic        start;
    logic [16:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
  } point_t;

  // one pair result as the block should present it
  typedef struct {
    logic signed [33:0] value;
    logic [5:0]         earlier;
    logic [5:0]         current;
    logic               last;
    logic               ovf;
  } pair_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 150;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [2:0]         cfg_data_i = 3'd0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               start_sample_i = 1'b0;
  logic signed [16:0] coord_0_i = '0;
  logic signed [15:0] coord_1_i = '0;
  logic signed [15:0] coord_2_i = '0;
  logic signed [15:0] coord_3_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [33:0] pair_value_o;
  logic [5:0]         earlier_index_o;
  logic [5:0]         current_index_o;
  logic               last_of_run_o;
  logic               overflow_o;

  pairwise_shortest_angle_core i_dut (.*);

  // testbench copy of the block state
  logic [15:0] shadow_store [64][4];
  int          shadow_count = 0;
  int          shadow_dim = 1;
  logic        shadow_raw = 1'b0;

  point_t pending_points [$];
  pair_t  expected_pairs [$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  longint cycle_count = 0;
  logic   in_taken = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // arc cosine of a q.30 value by vectoring rotation, 32768 = pi
  function automatic longint arc_cosine(longint x);
    longint unsigned mag, rem, root, bitv;
    longint cx, cy, z, nx, ny, t;
    longint atans [30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
    mag = (x < 0) ? -x : x;
    rem = (64'd1 << 60) - mag * mag;
    // bitwise integer square root of 1 - x^2
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    cy = root;
    cx = x;
    z  = 0;
    // negative cosine: pre-rotate by a quarter turn
    if (cx < 0) begin
      t  = cx;
      cx = cy;
      cy = -t;
      z  = 64'sd1 << 30;
    end
    for (int i = 0; i < 30; i++) begin
      if (cy == 0) break;
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z  = z + atans[i];
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z  = z - atans[i];
      end
      cx = nx;
      cy = ny;
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 << 31)) z = 64'sd1 << 31;
    return (z + 32768) >>> 16;
  endfunction

  // value of the pair (earlier a, current b) under the present mode
  function automatic longint pair_angle(int a, int b, int dim);
    longint d, dot;
    if (dim <= 1) begin
      d = longint'(shadow_store[a][0]) - longint'(shadow_store[b][0]);
      if (shadow_raw) return d;
      if (d < 0) d = -d;
      d = 32768 - d;
      if (d < 0) d = -d;
      return 32768 - d;
    end
    dot = 0;
    for (int k = 0; k < dim; k++)
      dot += longint'($signed(shadow_store[a][k])) * longint'($signed(shadow_store[b][k]));
    if (shadow_raw) return dot;
    // non-unit vectors: clamp to [-1,1] first
    if (dot > (64'sd1 << 30)) dot = 64'sd1 << 30;
    if (dot < -(64'sd1 << 30)) dot = -(64'sd1 << 30);
    return arc_cosine(dot);
  endfunction

  // store the accepted point and queue up every pair it causes
  task automatic predict_pairs(point_t p);
    int    dim;
    int    j;
    pair_t r;
    dim = shadow_dim;
    if (dim == 0) dim = 1;
    if (dim > 4) dim = 4;
    if (p.start) shadow_count = 0;
    if (shadow_count >= MAX_POINTS) begin
      // store full: point dropped, one flagged result
      r = '{value: '0, earlier: '0, current: '0, last: 1'b1, ovf: 1'b1};
      expected_pairs.push_back(r);
    end else begin
      j = shadow_count;
      shadow_store[j] = '{p.c0[15:0], p.c1, p.c2, p.c3};
      shadow_count = j + 1;
      for (int i = 0; i < j; i++) begin
        r.value   = 34'(pair_angle(i, j, dim));
        r.earlier = 6'(i);
        r.current = 6'(j);
        r.last    = (i + 1 == j);
        r.ovf     = 1'b0;
        expected_pairs.push_back(r);
      end
    end
  endtask

  // input acceptance, prediction and watchdog, all on the rising edge
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        predict_pairs('{start_sample_i, coord_0_i, coord_1_i, coord_2_i, coord_3_i});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("** pairwise_shortest_angle_core: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result checking against the oldest expected pair
  always @(posedge clk_i) begin
    pair_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pairs.size() == 0) begin
        $error("unexpected result: value %0d earlier %0d current %0d",
               pair_value_o, earlier_index_o, current_index_o);
        fail_count++;
      end else begin
        e = expected_pairs.pop_front();
        if (pair_value_o !== e.value) begin
          $error("pair_value: expected %0d, actual %0d", e.value, pair_value_o);
          fail_count++;
        end
        if (earlier_index_o !== e.earlier) begin
          $error("earlier_index: expected %0d, actual %0d", e.earlier, earlier_index_o);
          fail_count++;
        end
        if (current_index_o !== e.current) begin
          $error("current_index: expected %0d, actual %0d", e.current, current_index_o);
          fail_count++;
        end
        if (last_of_run_o !== e.last) begin
          $error("last_of_run: expected %0b, actual %0b", e.last, last_of_run_o);
          fail_count++;
        end
        if (overflow_o !== e.ovf) begin
          $error("overflow: expected %0b, actual %0b", e.ovf, overflow_o);
          fail_count++;
        end
      end
    end
  end

  // sender: idles at random about 32 in 100, apart from a regular stretch without idling
  always @(negedge clk_i) begin
    point_t p;
    logic   gap;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      gap = ((cycle_count % 4000) >= 1000) && ($urandom_range(0, 99) < 32);
      if (pending_points.size() != 0 && !gap) begin
        p = pending_points.pop_front();
        in_valid_i     <= 1'b1;
        start_sample_i <= p.start;
        coord_0_i      <= p.c0;
        coord_1_i      <= p.c1;
        coord_2_i      <= p.c2;
        coord_3_i      <= p.c3;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off so the pipeline backs up into the input
  int rx_cycles = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles >= 3000 && rx_cycles < 3400)
        out_ready_i <= 1'b0;
      else if ((rx_cycles % 4000) >= 1500 && (rx_cycles % 4000) < 2500)
        out_ready_i <= 1'b1;
      else
        out_ready_i <= ($urandom_range(0, 99) >= 32);
    end
  end

  function automatic point_t rand_point(logic start);
    point_t p;
    p.start = start;
    p.c0 = 17'($urandom_range(0, 98303) - 32768);
    p.c1 = 16'($urandom);
    p.c2 = 16'($urandom);
    p.c3 = 16'($urandom);
    return p;
  endfunction

  function automatic point_t vec_point(logic start, int a, int b, int c, int d);
    point_t p;
    p = '{start, 17'(a), 16'(b), 16'(c), 16'(d)};
    return p;
  endfunction

  // well-formed samples with random content, a little noise on the start flag
  task automatic add_random(int n);
    int made;
    int len;
    made = 0;
    while (made < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        pending_points.push_back(rand_point(k == 0 || $urandom_range(0, 19) == 0));
        made++;
      end
    end
  endtask

  // block idle: nothing queued, nothing in flight, then let the pipeline settle
  task automatic wait_quiet();
    while (pending_points.size() != 0 || in_valid_i || expected_pairs.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DIMENSION) shadow_dim = val;
    else shadow_raw = val[0];
  endtask

  task automatic run_phase(logic [2:0] dim, logic raw, int n);
    wait_quiet();
    write_reg(REG_DIMENSION, dim);
    write_reg(REG_RAW, raw);
    add_random(n);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // angular extremes, wrap of out-of-range angles, half and quarter turns
    pending_points.push_back(vec_point(1'b1, 0, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, 65535, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, 32768, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, -32768, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, 16384, -1, 1, 0));
    pending_points.push_back(vec_point(1'b0, -1, 0, 0, 0));
    pending_points.push_back(vec_point(1'b1, 49152, 0, 0, 0));
    wait_quiet();
    write_reg(REG_RAW, 1'b1);
    pending_points.push_back(vec_point(1'b1, 65535, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, 0, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, -32768, 0, 0, 0));

    // cartesian: parallel, opposite, orthogonal and non-unit vectors
    wait_quiet();
    write_reg(REG_DIMENSION, 3'd2);
    write_reg(REG_RAW, 1'b0);
    pending_points.push_back(vec_point(1'b1, 32767, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, 32767, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, -32768, 0, 0, 0));
    pending_points.push_back(vec_point(1'b0, 0, 32767, 0, 0));
    pending_points.push_back(vec_point(1'b0, -32768, -32768, 0, 0));
    pending_points.push_back(vec_point(1'b0, 23170, -23170, 0, 0));
    pending_points.push_back(vec_point(1'b0, 65535, 32767, 0, 0));
    wait_quiet();
    write_reg(REG_DIMENSION, 3'd4);
    pending_points.push_back(vec_point(1'b1, 16384, 16384, 16384, 16384));
    pending_points.push_back(vec_point(1'b0, -16384, 16384, -16384, 16384));
    pending_points.push_back(vec_point(1'b0, 32767, 32767, 32767, 32767));
    pending_points.push_back(vec_point(1'b0, -32768, -32768, -32768, -32768));

    // mode changed within a sample: stored words reread as angles
    wait_quiet();
    write_reg(REG_DIMENSION, 3'd1);
    pending_points.push_back(vec_point(1'b0, 1000, 0, 0, 0));

    // full store: 64 points, then two dropped ones
    run_phase(3'd1, 1'b1, 0);
    for (int k = 0; k < 66; k++) pending_points.push_back(rand_point(k == 0));

    run_phase(3'd1, 1'b0, 10);
    run_phase(3'd2, 1'b0, 10);
    run_phase(3'd4, 1'b0, 10);
    run_phase(3'd3, 1'b1, 8);
    run_phase(3'd4, 1'b1, 8);
    run_phase(3'd0, 1'b0, 5);
    run_phase(3'd7, 1'b0, 5);
    run_phase(3'd5, 1'b1, 4);

    wait_quiet();
    if (fail_count == 0 && expected_pairs.size() == 0) begin
      $display("** pairwise_shortest_angle_core: PASSED **");
    end else begin
      $display("** pairwise_shortest_angle_core: FAILED **");
    end
    $finish;
  end

endmodule
